[hw/rtl/assert_macros.svh]
// Assertion helpers for the box suppression block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Condition that must hold at every edge, reset included
`define ASSERT_ALWAYS(label, clk, cond, msg) \
  label: assert property (@(posedge clk) (cond)) else $error(msg);

`endif

[hw/rtl/cbn_pkg.sv]
// ---------------------------------------------------------------------------
// cbn_pkg
// Shared constants and types for per-class box suppression.
// ---------------------------------------------------------------------------
package cbn_pkg;

  localparam int unsigned MaxBoxes   = 64;
  localparam int unsigned NumClasses = 80;
  localparam int unsigned CoordW     = 16;
  localparam int unsigned ConfW      = 16;
  localparam int unsigned ClassW     = 7;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 64;

  // Register indexes
  localparam logic [CfgIdxW-1:0] RegScoreThr   = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOverlapThr = 2'd1;
  localparam logic [CfgIdxW-1:0] RegMaskLow    = 2'd2;
  localparam logic [CfgIdxW-1:0] RegMaskHigh   = 2'd3;

  localparam logic [15:0] ScoreThrReset   = 16'd32768;
  localparam logic [15:0] OverlapThrReset = 16'd29491;

  typedef struct packed {
    logic [CoordW-1:0] center_x;
    logic [CoordW-1:0] center_y;
    logic [CoordW-1:0] box_width;
    logic [CoordW-1:0] box_height;
    logic [ConfW-1:0]  confidence;
    logic [ClassW-1:0] class_index;
    logic              last_candidate;
  } cand_t;

  typedef struct packed {
    logic [CoordW-1:0] kept_center_x;
    logic [CoordW-1:0] kept_center_y;
    logic [CoordW-1:0] kept_width;
    logic [CoordW-1:0] kept_height;
    logic [ConfW-1:0]  kept_confidence;
    logic [ClassW-1:0] kept_class;
    logic              final_result;
    logic              none_kept;
  } kept_t;

  typedef struct packed {
    logic [CoordW-1:0] cx;
    logic [CoordW-1:0] cy;
    logic [CoordW-1:0] w;
    logic [CoordW-1:0] h;
  } geom_t;

  // Overlap unit request / response
  typedef struct packed {
    logic  start;
    geom_t a;
    geom_t b;
  } ovl_req_t;

  typedef struct packed {
    logic done;
    logic hit;
  } ovl_rsp_t;

endpackage

[hw/rtl/cbn_stream_if.sv]
// ---------------------------------------------------------------------------
// cbn_stream_if
// Valid/ready channel carrying one payload item.
// ---------------------------------------------------------------------------
interface cbn_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/cbn_overlap.sv]
// ---------------------------------------------------------------------------
// cbn_overlap
// Multi-cycle IoU test: inter*65536 > thresh*union on doubled edges.
// ---------------------------------------------------------------------------
module cbn_overlap
  import cbn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] thresh,
  input  ovl_req_t    req,
  output ovl_rsp_t    rsp
);

  // Stage valid shift line
  logic [3:0] vld_r;

  // Stage 1: edges and intersection extents (19-bit signed)
  logic signed [18:0] il_r, ir_r, it_r, ib_r;
  logic [15:0]        aw_r, ah_r, bw_r, bh_r;

  // Stage 2: products
  logic [37:0] inter_r;
  logic [33:0] area_a_r, area_b_r;
  logic        disj_r;

  // Stage 3: union
  logic [37:0] inter2_r;
  logic signed [36:0] uni_r;
  logic        disj2_r;

  logic signed [18:0] al, ar, at, ab, bl, br, bt, bb;
  logic signed [19:0] dx, dy;
  logic signed [54:0] lhs, rhs;
  logic [35:0] sum_area;

  always_comb begin
    al = $signed({2'b0, req.a.cx, 1'b0}) - $signed({3'b0, req.a.w});
    ar = $signed({2'b0, req.a.cx, 1'b0}) + $signed({3'b0, req.a.w});
    at = $signed({2'b0, req.a.cy, 1'b0}) - $signed({3'b0, req.a.h});
    ab = $signed({2'b0, req.a.cy, 1'b0}) + $signed({3'b0, req.a.h});
    bl = $signed({2'b0, req.b.cx, 1'b0}) - $signed({3'b0, req.b.w});
    br = $signed({2'b0, req.b.cx, 1'b0}) + $signed({3'b0, req.b.w});
    bt = $signed({2'b0, req.b.cy, 1'b0}) - $signed({3'b0, req.b.h});
    bb = $signed({2'b0, req.b.cy, 1'b0}) + $signed({3'b0, req.b.h});
    dx = {ir_r[18], ir_r} - {il_r[18], il_r};
    dy = {ib_r[18], ib_r} - {it_r[18], it_r};
  end

  // Advance the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[2:0], req.start};
    end
    il_r <= (al > bl) ? al : bl;
    ir_r <= (ar < br) ? ar : br;
    it_r <= (at > bt) ? at : bt;
    ib_r <= (ab < bb) ? ab : bb;
    aw_r <= req.a.w;
    ah_r <= req.a.h;
    bw_r <= req.b.w;
    bh_r <= req.b.h;
    disj_r   <= dx[19] || dy[19];
    inter_r  <= 38'(dx[18:0]) * 38'(dy[18:0]);
    area_a_r <= 34'({aw_r, 2'b0}) * 34'(ah_r);
    area_b_r <= 34'({bw_r, 2'b0}) * 34'(bh_r);
    inter2_r <= inter_r;
    disj2_r  <= disj_r;
    uni_r    <= $signed({1'b0, sum_area}) - $signed(inter_r[36:0]);
  end

  assign sum_area = 36'(area_a_r) + 36'(area_b_r);
  assign lhs = $signed({1'b0, inter2_r[37:0], 16'b0});
  assign rhs = 55'($signed({1'b0, thresh})) * 55'(uni_r);

  logic hit_r;
  always_ff @(posedge clk) begin
    hit_r <= !disj2_r && (lhs > rhs);
  end

  assign rsp.done = vld_r[3];
  assign rsp.hit  = hit_r;

endmodule

[hw/rtl/classwise_box_nms.sv]
// ---------------------------------------------------------------------------
// classwise_box_nms
// Per-class greedy suppression of candidate boxes held in on-chip memory.
// ---------------------------------------------------------------------------
// channel | dir | payload                                   | accept
// in_     | in  | box, confidence, class, last flag         | valid & ready
// out_    | out | kept box, confidence, class, final, none  | valid & ready
// cfg_    | in  | index, 64-bit data                        | we
//
// Loading: one candidate per cycle while collecting.
// Suppression: each class is scanned over all N stored boxes for its best live box.
// Each kept box adds a suppression pass that reads every stored box and runs the
// overlap unit on each live box of its class, followed by a rescan of the class.
// Reset is synchronous; the memories need no clearing pass.
// Input stalls during suppression; output backpressure holds the sequencer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"
module classwise_box_nms
  import cbn_pkg::*;
#(
  parameter int unsigned MAX_BOXES   = MaxBoxes,
  parameter int unsigned NUM_CLASSES = NumClasses
) (
  input  logic                clk,
  input  logic                rst_n,
  cbn_stream_if.sink          in_ch,
  cbn_stream_if.source        out_ch,
  input  logic                cfg_we,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data
);

  localparam int unsigned AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int unsigned CW = $clog2(MAX_BOXES + 1);

  typedef enum logic [7:0] {
    S_LOAD  = 8'b0000_0001,
    S_SCAN  = 8'b0000_0010,
    S_PICK  = 8'b0000_0100,
    S_EMIT  = 8'b0000_1000,
    S_SUPP  = 8'b0001_0000,
    S_WAIT  = 8'b0010_0000,
    S_NEXT  = 8'b0100_0000,
    S_DONE  = 8'b1000_0000
  } state_t;

  // Configuration
  logic [15:0] score_thr_r, ovl_thr_r, mask_hi_r;
  logic [63:0] mask_lo_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_thr_r <= ScoreThrReset;
      ovl_thr_r   <= OverlapThrReset;
      mask_lo_r   <= '1;
      mask_hi_r   <= '1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        RegScoreThr:   score_thr_r <= cfg_data[15:0];
        RegOverlapThr: ovl_thr_r   <= cfg_data[15:0];
        RegMaskLow:    mask_lo_r   <= cfg_data;
        RegMaskHigh:   mask_hi_r   <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Memories: geometry and score/class; flags in flip-flops
  geom_t            geo_mem [MAX_BOXES];
  logic [22:0]      sc_mem  [MAX_BOXES];
  logic [MAX_BOXES-1:0] supp_r;

  state_t        state_r;
  logic [CW-1:0] count_r;
  logic [CW-1:0] idx_r;
  logic [AW-1:0] rd_addr;
  geom_t         geo_rd_r;
  logic [22:0]   sc_rd_r;
  logic          rd_vld_r;
  logic [AW-1:0] rd_idx_r;
  logic [6:0]    cls_r;
  logic          found_r;
  logic [AW-1:0] best_r;
  logic [15:0]   best_conf_r;
  geom_t         best_geo_r;
  logic          any_r;
  kept_t         hold_r;
  kept_t         hold_fin;
  kept_t         out_r;
  logic          out_vld_r;
  ovl_req_t      oreq;
  ovl_rsp_t      orsp;

  cand_t cin;
  assign cin = in_ch.data;

  logic allowed, store_en;
  always_comb begin
    if (cin.class_index >= 7'(NUM_CLASSES) || cin.class_index >= 7'd80) begin
      allowed = 1'b0;
    end else if (cin.class_index < 7'd64) begin
      allowed = mask_lo_r[cin.class_index[5:0]];
    end else begin
      allowed = mask_hi_r[cin.class_index[3:0]];
    end
  end

  assign in_ch.ready = (state_r == S_LOAD);
  logic in_acc;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign store_en = in_acc && allowed && (cin.confidence > score_thr_r)
                    && (count_r < CW'(MAX_BOXES));

  // Write port
  always_ff @(posedge clk) begin
    if (store_en) begin
      geo_mem[count_r[AW-1:0]] <= '{cin.center_x, cin.center_y,
                                    cin.box_width, cin.box_height};
      sc_mem[count_r[AW-1:0]]  <= {cin.class_index, cin.confidence};
    end
  end

  // Read port, registered; the index follows only issued reads
  logic rd_en;
  assign rd_addr = idx_r[AW-1:0];
  assign rd_en = ((state_r == S_SCAN) || (state_r == S_SUPP)) && (idx_r < count_r);
  always_ff @(posedge clk) begin
    geo_rd_r <= geo_mem[rd_addr];
    sc_rd_r  <= sc_mem[rd_addr];
    if (rd_en) rd_idx_r <= rd_addr;
  end

  logic cand_ok;
  assign cand_ok = rd_vld_r && !supp_r[rd_idx_r] && (sc_rd_r[22:16] == cls_r);

  assign oreq.start = (state_r == S_WAIT) && rd_vld_r && cand_ok;
  assign oreq.a     = best_geo_r;
  assign oreq.b     = geo_rd_r;

  cbn_overlap u_ovl (
    .clk    (clk),
    .rst_n  (rst_n),
    .thresh (ovl_thr_r),
    .req    (oreq),
    .rsp    (orsp)
  );

  logic out_free;
  assign out_free = !out_vld_r || out_ch.ready;

  // Mark the held item as the last one of the set
  always_comb begin
    hold_fin = hold_r;
    hold_fin.final_result = 1'b1;
  end

  // Offer an item when a held one is released or the set closes
  logic out_set;
  assign out_set = out_free && (((state_r == S_EMIT) && any_r) || (state_r == S_DONE));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_set) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      count_r   <= '0;
      idx_r     <= '0;
      supp_r    <= '0;
      rd_vld_r  <= 1'b0;
      found_r   <= 1'b0;
      any_r     <= 1'b0;
      cls_r     <= '0;
    end else begin
      rd_vld_r <= rd_en;
      unique case (state_r)
        S_LOAD: begin
          if (store_en) begin
            count_r <= count_r + CW'(1);
            supp_r[count_r[AW-1:0]] <= 1'b0;
          end
          if (in_acc && cin.last_candidate) begin
            state_r <= S_SCAN;
            idx_r   <= '0;
            cls_r   <= '0;
            found_r <= 1'b0;
            any_r   <= 1'b0;
          end
        end
        S_SCAN: begin
          // Stream addresses; compare returning data
          if (idx_r < count_r) idx_r <= idx_r + CW'(1);
          if (cand_ok && (!found_r || sc_rd_r[15:0] > best_conf_r)) begin
            found_r     <= 1'b1;
            best_r      <= rd_idx_r;
            best_conf_r <= sc_rd_r[15:0];
            best_geo_r  <= geo_rd_r;
          end
          if (idx_r >= count_r && !rd_vld_r) state_r <= S_PICK;
        end
        S_PICK: begin
          if (found_r) begin
            state_r <= S_EMIT;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_EMIT: begin
          // Hold previous result back by one slot to mark the final one
          if (out_free) begin
            if (any_r) out_r <= hold_r;
            hold_r <= '{best_geo_r.cx, best_geo_r.cy, best_geo_r.w, best_geo_r.h,
                        best_conf_r, cls_r, 1'b0, 1'b0};
            any_r <= 1'b1;
            supp_r[best_r] <= 1'b1;
            idx_r   <= '0;
            state_r <= S_SUPP;
          end
        end
        S_SUPP: begin
          // Read one entry, then test it
          if (rd_en) begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_WAIT;
          end else begin
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_WAIT: begin
          if (rd_vld_r && !cand_ok) begin
            state_r <= S_SUPP;
          end else if (orsp.done) begin
            if (orsp.hit) supp_r[rd_idx_r] <= 1'b1;
            state_r <= S_SUPP;
          end
        end
        S_NEXT: begin
          if (cls_r == 7'(NUM_CLASSES - 1)) begin
            state_r <= S_DONE;
          end else begin
            cls_r   <= cls_r + 7'd1;
            idx_r   <= '0;
            found_r <= 1'b0;
            state_r <= S_SCAN;
          end
        end
        S_DONE: begin
          if (out_free) begin
            if (any_r) begin
              out_r <= hold_fin;
            end else begin
              out_r <= '{16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 7'd0, 1'b1, 1'b1};
            end
            count_r <= '0;
            supp_r  <= '0;
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  // S_WAIT holds rd_idx_r stable because no new read is issued there
  always_comb begin
    out_ch.valid = out_vld_r;
    out_ch.data  = out_r;
  end

  `ASSERT_ALWAYS(a_onehot, clk, !rst_n || $onehot(state_r), "state not one-hot")
  `ASSERT_IMPL(a_cnt, clk, rst_n, count_r <= CW'(MAX_BOXES), "count overflow")
  `ASSERT_IMPL(a_rdy, clk, rst_n, in_ch.ready |-> count_r <= CW'(MAX_BOXES), "ready bad")
  `ASSERT_IMPL(a_hold, clk, rst_n, (out_vld_r && !out_ch.ready) |=> $stable(out_r), "out moved")

endmodule

[bench/tb_classwise_box_nms.sv]
// ---------------------------------------------------------------------------
// tb_classwise_box_nms
// Self-checking bench for per-class box suppression. Candidate sets are
// streamed through the input channel. Kept boxes are compared field by field
// against an in-bench model of the greedy suppression. The run covers
// directed edge cases, random sets under several register settings, random
// idling on both channels, a long output stall and a drained pause.
// ---------------------------------------------------------------------------
module tb_classwise_box_nms;
  import cbn_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 3000000;
  localparam int unsigned DrainWait  = 300;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CfgIdxW-1:0]  cfg_index;
  logic [CfgDataW-1:0] cfg_data;

  cbn_stream_if #(.payload_t(cand_t)) cand_ch ();
  cbn_stream_if #(.payload_t(kept_t)) kept_ch ();

  classwise_box_nms u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (cand_ch),
    .out_ch    (kept_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Bench copy of registers and box store
  logic [15:0] score_thr;
  logic [15:0] overlap_thr;
  logic [63:0] mask_low;
  logic [15:0] mask_high;
  geom_t       box_geom [MaxBoxes];
  logic [15:0] box_conf [MaxBoxes];
  logic [6:0]  box_class [MaxBoxes];
  bit          box_dropped [MaxBoxes];
  int unsigned box_count;

  kept_t kept_q[$];

  int unsigned errors;
  int unsigned cycles;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned sets_closed;
  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          rx_hold;

  // Directed stimulus row: typed expectation only where obvious
  typedef struct {
    cand_t cand;
    bit    typed;
    kept_t kept;
  } row_t;

  row_t rows[$];

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Count cycles, stop on runaway
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles, kept_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input longint got, input longint want);
    errors++;
    $display("mismatch %s: got %0d want %0d (result %0d)", what, got, want, results_seen);
  endtask

  function automatic bit class_allowed(input logic [6:0] cls);
    if (cls >= NumClasses || cls >= 80) return 1'b0;
    if (cls < 64) return mask_low[cls];
    return mask_high[cls - 64];
  endfunction

  // Overlap test on doubled edges, integer only
  function automatic bit overlaps_too_much(input geom_t a, input geom_t b);
    longint al, ar, at, ab, bl, br, bt, bb, il, ir, it, ib, inter, uni;
    al = 2 * longint'(a.cx) - longint'(a.w);
    ar = 2 * longint'(a.cx) + longint'(a.w);
    at = 2 * longint'(a.cy) - longint'(a.h);
    ab = 2 * longint'(a.cy) + longint'(a.h);
    bl = 2 * longint'(b.cx) - longint'(b.w);
    br = 2 * longint'(b.cx) + longint'(b.w);
    bt = 2 * longint'(b.cy) - longint'(b.h);
    bb = 2 * longint'(b.cy) + longint'(b.h);
    il = (al > bl) ? al : bl;
    ir = (ar < br) ? ar : br;
    it = (at > bt) ? at : bt;
    ib = (ab < bb) ? ab : bb;
    if (it > ib || il > ir) return 1'b0;
    inter = (ir - il) * (ib - it);
    uni = 4 * longint'(a.w) * longint'(a.h) + 4 * longint'(b.w) * longint'(b.h) - inter;
    return inter * 65536 > longint'(overlap_thr) * uni;
  endfunction

  // Store one candidate; on the last one run suppression and queue kept boxes
  task automatic absorb_candidate(input cand_t c, input bit push);
    int best;
    int unsigned n;
    kept_t k;
    n = 0;
    if (c.confidence > score_thr && class_allowed(c.class_index) && box_count < MaxBoxes) begin
      box_geom[box_count]    = '{cx: c.center_x, cy: c.center_y, w: c.box_width,
                                 h: c.box_height};
      box_conf[box_count]    = c.confidence;
      box_class[box_count]   = c.class_index;
      box_dropped[box_count] = 1'b0;
      box_count++;
    end
    if (!c.last_candidate) return;
    sets_closed++;
    for (int cl = 0; cl < NumClasses; cl++) begin
      forever begin
        best = -1;
        for (int i = 0; i < box_count; i++) begin
          if (box_dropped[i] || box_class[i] != cl) continue;
          if (best < 0 || box_conf[i] > box_conf[best]) best = i;
        end
        if (best < 0) break;
        box_dropped[best] = 1'b1;
        k = '0;
        k.kept_center_x   = box_geom[best].cx;
        k.kept_center_y   = box_geom[best].cy;
        k.kept_width      = box_geom[best].w;
        k.kept_height     = box_geom[best].h;
        k.kept_confidence = box_conf[best];
        k.kept_class      = 7'(cl);
        if (push) kept_q.insert(kept_q.size(), k);
        n++;
        for (int i = 0; i < box_count; i++) begin
          if (box_dropped[i] || box_class[i] != cl) continue;
          if (overlaps_too_much(box_geom[best], box_geom[i])) box_dropped[i] = 1'b1;
        end
      end
    end
    if (push) begin
      if (n == 0) begin
        k = '0;
        k.final_result = 1'b1;
        k.none_kept    = 1'b1;
        kept_q.insert(kept_q.size(), k);
      end else begin
        kept_q[kept_q.size() - 1].final_result = 1'b1;
      end
    end
    for (int i = 0; i < MaxBoxes; i++) box_dropped[i] = 1'b0;
    box_count = 0;
  endtask

  // Accept results and compare with the oldest expectation
  always @(posedge clk) begin
    kept_t got, want;
    if (rst_n && kept_ch.valid && kept_ch.ready) begin
      got = kept_ch.data;
      results_seen++;
      if (kept_q.size() == 0) begin
        report_mismatch("unexpected result, class", got.kept_class, 0);
      end else begin
        want = kept_q.pop_front();
        if (got.kept_center_x !== want.kept_center_x)
          report_mismatch("center_x", got.kept_center_x, want.kept_center_x);
        if (got.kept_center_y !== want.kept_center_y)
          report_mismatch("center_y", got.kept_center_y, want.kept_center_y);
        if (got.kept_width !== want.kept_width)
          report_mismatch("width", got.kept_width, want.kept_width);
        if (got.kept_height !== want.kept_height)
          report_mismatch("height", got.kept_height, want.kept_height);
        if (got.kept_confidence !== want.kept_confidence)
          report_mismatch("confidence", got.kept_confidence, want.kept_confidence);
        if (got.kept_class !== want.kept_class)
          report_mismatch("class", got.kept_class, want.kept_class);
        if (got.final_result !== want.final_result)
          report_mismatch("final_result", got.final_result, want.final_result);
        if (got.none_kept !== want.none_kept)
          report_mismatch("none_kept", got.none_kept, want.none_kept);
      end
    end
    kept_ch.ready <= !rx_hold && ($urandom_range(99) >= rcv_idle_pct);
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      RegScoreThr:   score_thr   = val[15:0];
      RegOverlapThr: overlap_thr = val[15:0];
      RegMaskLow:    mask_low    = val;
      RegMaskHigh:   mask_high   = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_registers(input logic [15:0] st, input logic [15:0] ot,
                               input logic [63:0] ml, input logic [15:0] mh);
    write_reg(RegScoreThr, {48'(0), st});
    write_reg(RegOverlapThr, {48'(0), ot});
    write_reg(RegMaskLow, ml);
    write_reg(RegMaskHigh, {48'(0), mh});
  endtask

  // Offer one item, hold until accepted, then update the model
  task automatic offer_candidate(input cand_t c, input bit push);
    if ($urandom_range(99) < snd_idle_pct) begin
      cand_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    cand_ch.valid <= 1'b1;
    cand_ch.data  <= c;
    do @(posedge clk); while (!cand_ch.ready);
    items_sent++;
    absorb_candidate(c, push);
  endtask

  // Idle the sender until every expected result is in, then let the block settle
  task automatic wait_drained();
    cand_ch.valid <= 1'b0;
    while (kept_q.size() != 0) @(posedge clk);
    repeat (DrainWait) @(posedge clk);
  endtask

  function automatic cand_t random_box(input bit last, input int unsigned bx,
                                       input int unsigned by);
    cand_t c;
    c = '0;
    if ($urandom_range(7) == 0) begin
      // noise: all fields but the last flag fully random
      c.center_x    = 16'($urandom);
      c.center_y    = 16'($urandom);
      c.box_width   = 16'($urandom);
      c.box_height  = 16'($urandom);
      c.confidence  = 16'($urandom);
      c.class_index = 7'($urandom);
    end else begin
      c.center_x    = 16'(bx + $urandom_range(0, 96));
      c.center_y    = 16'(by + $urandom_range(0, 96));
      c.box_width   = 16'($urandom_range(0, 600));
      c.box_height  = 16'($urandom_range(0, 600));
      c.confidence  = (score_thr == 16'hFFFF) ? 16'($urandom)
                      : 16'($urandom_range(score_thr + 1, 65535));
      case ($urandom_range(5))
        0: c.class_index = 7'd0;
        1: c.class_index = 7'd63;
        2: c.class_index = 7'd64;
        3: c.class_index = 7'd79;
        default: c.class_index = 7'($urandom_range(1, 3));
      endcase
    end
    c.last_candidate = last;
    return c;
  endfunction

  // Random sets until the item budget is spent; one set may overflow the store
  task automatic run_sets(input int unsigned budget, input bit with_full_set,
                          input bit with_stall);
    int unsigned done_items, size, bx, by, set_no;
    done_items = 0;
    set_no = 0;
    while (done_items < budget) begin
      if (with_full_set && set_no == 2) size = MaxBoxes + 6;
      else if ($urandom_range(9) == 0) size = $urandom_range(8, 16);
      else size = $urandom_range(1, 6);
      bx = $urandom_range(0, 65000);
      by = $urandom_range(0, 65000);
      for (int k = 0; k < size; k++) begin
        // hold the output for a long stretch while the last item goes in
        if (with_stall && set_no == 1 && k == size - 1) begin
          fork
            begin
              rx_hold <= 1'b1;
              repeat (1500) @(posedge clk);
              rx_hold <= 1'b0;
            end
          join_none
        end
        offer_candidate(random_box(k == size - 1, bx, by), 1'b1);
      end
      done_items += size;
      set_no++;
      if (set_no == 4) wait_drained();
    end
    wait_drained();
  endtask

  function automatic cand_t mk(input int unsigned cx, input int unsigned cy,
                               input int unsigned w, input int unsigned h,
                               input int unsigned conf, input int unsigned cls,
                               input bit last);
    cand_t c;
    c.center_x = 16'(cx); c.center_y = 16'(cy);
    c.box_width = 16'(w); c.box_height = 16'(h);
    c.confidence = 16'(conf); c.class_index = 7'(cls);
    c.last_candidate = last;
    return c;
  endfunction

  function automatic kept_t kept_of(input cand_t c);
    kept_t k;
    k = '0;
    k.kept_center_x = c.center_x; k.kept_center_y = c.center_y;
    k.kept_width = c.box_width; k.kept_height = c.box_height;
    k.kept_confidence = c.confidence; k.kept_class = c.class_index;
    k.final_result = 1'b1;
    return k;
  endfunction

  task automatic add_row(input cand_t c, input bit typed, input kept_t k);
    row_t r;
    r.cand = c; r.typed = typed; r.kept = k;
    rows.insert(rows.size(), r);
  endtask

  task automatic build_rows();
    kept_t none, z;
    cand_t c;
    none = '0; none.final_result = 1'b1; none.none_kept = 1'b1;
    z = '0;
    // nothing stored: zero confidence, confidence equal to threshold
    add_row(mk(100, 100, 10, 10, 0, 0, 1), 1, none);
    add_row(mk(100, 100, 10, 10, 32768, 0, 1), 1, none);
    // single box, extremes of geometry and confidence
    c = mk(65535, 65535, 65535, 65535, 65535, 0, 1);
    add_row(c, 1, kept_of(c));
    c = mk(0, 0, 0, 0, 32769, 79, 1);
    add_row(c, 1, kept_of(c));
    // class out of range
    add_row(mk(500, 500, 40, 40, 65535, 80, 1), 1, none);
    add_row(mk(500, 500, 40, 40, 65535, 127, 1), 1, none);
    // identical boxes with a tie: earlier one wins, later one suppressed
    add_row(mk(800, 800, 100, 100, 40000, 5, 0), 0, z);
    add_row(mk(800, 800, 100, 100, 40000, 5, 0), 0, z);
    add_row(mk(810, 805, 100, 90, 50000, 3, 0), 0, z);
    add_row(mk(900, 900, 60, 60, 45000, 3, 1), 0, z);
    // disjoint and touching boxes of one class, plus two higher classes after
    add_row(mk(100, 100, 20, 20, 60000, 10, 0), 0, z);
    add_row(mk(120, 100, 20, 20, 61000, 10, 0), 0, z);
    add_row(mk(3000, 3000, 20, 20, 59000, 10, 0), 0, z);
    add_row(mk(110, 100, 20, 20, 62000, 10, 0), 0, z);
    add_row(mk(100, 100, 20, 20, 33000, 64, 0), 0, z);
    add_row(mk(100, 100, 20, 20, 33000, 63, 1), 0, z);
    // partial overlap near the threshold, boxes reaching past zero
    add_row(mk(5, 5, 200, 200, 50000, 2, 0), 0, z);
    add_row(mk(10, 8, 200, 200, 49000, 2, 0), 0, z);
    add_row(mk(60, 60, 200, 200, 48000, 2, 1), 0, z);
  endtask

  initial begin
    cand_ch.valid = 1'b0;
    cand_ch.data  = '0;
    kept_ch.ready = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    rst_n         = 1'b0;
    rx_hold       = 1'b0;
    cycles        = 0;
    errors        = 0;
    items_sent    = 0;
    results_seen  = 0;
    sets_closed   = 0;
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    score_thr     = ScoreThrReset;
    overlap_thr   = OverlapThrReset;
    mask_low      = '1;
    mask_high     = '1;
    box_count     = 0;
    for (int i = 0; i < MaxBoxes; i++) box_dropped[i] = 1'b0;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows under reset settings
    build_rows();
    foreach (rows[i]) begin
      if (rows[i].typed) kept_q.insert(kept_q.size(), rows[i].kept);
      offer_candidate(rows[i].cand, !rows[i].typed);
    end
    wait_drained();

    // sender sparse, receiver mostly stalled
    snd_idle_pct = 27;
    rcv_idle_pct = 74;
    set_registers(16'h0000, 16'h0000, 64'($urandom) << 32 | 64'($urandom), 16'($urandom));
    run_sets(60, 1'b0, 1'b1);

    // roles swapped, strict overlap, upper classes only
    snd_idle_pct = 74;
    rcv_idle_pct = 27;
    set_registers(16'($urandom_range(0, 40000)), 16'hFFFF, 64'h0, 16'hFFFF);
    run_sets(50, 1'b0, 1'b0);

    // no idling, all classes, one set overflows the store
    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    set_registers(16'($urandom_range(0, 30000)), 16'($urandom_range(1000, 50000)),
                  64'hFFFF_FFFF_FFFF_FFFF, 16'hFFFF);
    run_sets(110, 1'b1, 1'b1);

    // highest threshold and empty masks: only empty sets come back
    set_registers(16'hFFFF, 16'($urandom), 64'h0, 16'h0);
    run_sets(10, 1'b0, 1'b0);

    wait_drained();
    $display("covered %0d items in %0d sets, %0d results checked, %0d mismatches",
             items_sent, sets_closed, results_seen, errors);
    $display("settings: threshold extremes, empty and full masks, store overflow, long stall");
    if (errors == 0 && kept_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
